/* design/ipfc_pkg.sv */
// ipfc_pkg: types, codes and constants for the IP pair flow counter table.
// No dependencies; used by every other file in design/ but ipfc_if.
`timescale 1ns / 1ps
package ipfc_pkg;
  localparam int TableEntriesDefault = 32;
  localparam logic [15:0] EthIpv4 = 16'h0800;
  localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] CFG_MIN_PACKETS = 2'd0;
  localparam logic [1:0] CFG_MIN_BYTES = 2'd1;
  localparam logic [1:0] CFG_HEADER_BYTES = 2'd2;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  localparam logic [1:0] ST_COUNTED = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  typedef enum logic [1:0] {CMD_IGNORE, CMD_COUNT, CMD_DUMP} cmd_t;

  // classified item handed from front to back
  typedef struct packed {
    cmd_t        cmd;
    logic        tx;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [15:0] size;
  } work_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [31:0] high_addr;
    logic [31:0] low_addr;
    logic [47:0] tx_byte_count;
    logic [31:0] tx_packet_count;
    logic [47:0] rx_byte_count;
    logic [31:0] rx_packet_count;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_SEARCH, BK_UPDATE, BK_DUMP, BK_DUMP_CHK, BK_EMIT, BK_END
  } bk_state_t;
endpackage

/* design/ipfc_if.sv */
// ipfc_if: valid/ready channel interfaces for items and results.
// No dependencies.
`timescale 1ns / 1ps
interface ipfc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] eth_type;
  logic [31:0] source_addr;
  logic [31:0] dest_addr;
  logic [15:0] frame_length;
  modport source(output valid, operation, eth_type, source_addr, dest_addr,
                 frame_length, input ready);
  modport sink(input valid, operation, eth_type, source_addr, dest_addr,
               frame_length, output ready);
endinterface

interface ipfc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  status;
  logic [31:0] high_addr;
  logic [31:0] low_addr;
  logic [47:0] tx_byte_count;
  logic [31:0] tx_packet_count;
  logic [47:0] rx_byte_count;
  logic [31:0] rx_packet_count;
  logic        last;
  modport source(output valid, kind, status, high_addr, low_addr, tx_byte_count,
                 tx_packet_count, rx_byte_count, rx_packet_count, last,
                 input ready);
  modport sink(input valid, kind, status, high_addr, low_addr, tx_byte_count,
               tx_packet_count, rx_byte_count, rx_packet_count, last,
               output ready);
endinterface

/* design/ipfc_front.sv */
// ipfc_front: accepts items, classifies them, pushes into a 2-deep queue.
// Depends on ipfc_pkg.
`timescale 1ns / 1ps
module ipfc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 operation,
  input  logic [15:0]          eth_type,
  input  logic [31:0]          source_addr,
  input  logic [31:0]          dest_addr,
  input  logic [15:0]          frame_length,
  input  logic [7:0]           header_bytes,
  output logic                 q_valid,
  input  logic                 q_pop,
  output ipfc_pkg::work_t      q_data
);
  ipfc_pkg::work_t slot_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic rd_r, wr_r;
  ipfc_pkg::work_t w;
  logic push;

  always_comb begin
    w.tx = source_addr > dest_addr;
    w.hi = w.tx ? source_addr : dest_addr;
    w.lo = w.tx ? dest_addr : source_addr;
    w.size = (frame_length > {8'd0, header_bytes}) ?
             frame_length - {8'd0, header_bytes} : 16'd0;
    if (operation) w.cmd = ipfc_pkg::CMD_DUMP;
    else if (eth_type != ipfc_pkg::EthIpv4) w.cmd = ipfc_pkg::CMD_IGNORE;
    else w.cmd = ipfc_pkg::CMD_COUNT;
  end

  assign in_ready = cnt_r != 2'd2;
  assign push = in_valid && in_ready;
  assign q_valid = cnt_r != 2'd0;
  assign q_data = slot_r[rd_r];
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; rd_r <= 1'b0; wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (q_pop) rd_r <= ~rd_r;
    end
  end
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= w;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n) (cnt_r == 2'd2) |-> !in_ready)
    else $error("ready while queue full");
endmodule

/* design/ipfc_back.sv */
// ipfc_back: table search, counter update and dump walk over flop stores.
// Depends on ipfc_pkg.
`timescale 1ns / 1ps
module ipfc_back #(
  parameter int TABLE_ENTRIES = ipfc_pkg::TableEntriesDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  ipfc_pkg::work_t      q_data,
  input  logic [31:0]          min_packets,
  input  logic [31:0]          min_bytes,
  output logic                 res_valid,
  input  logic                 res_ready,
  output ipfc_pkg::result_t    res
);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  logic              valid_r [TABLE_ENTRIES];
  logic [63:0]       key_r   [TABLE_ENTRIES];
  logic [47:0]       txb_r   [TABLE_ENTRIES];
  logic [47:0]       rxb_r   [TABLE_ENTRIES];
  logic [31:0]       txp_r   [TABLE_ENTRIES];
  logic [31:0]       rxp_r   [TABLE_ENTRIES];
  logic [CW-1:0]     used_r;

  ipfc_pkg::bk_state_t st_r, st_nxt;
  ipfc_pkg::work_t     cur_r;
  logic [IW-1:0]       idx_r;
  logic [CW-1:0]       walk_r;
  logic                hit_r;
  logic [IW-1:0]       hit_idx_r;
  logic [1:0]          stat_r;
  ipfc_pkg::result_t   res_r, res_nxt;
  logic                res_v_r, res_v_nxt;
  logic                emit_status, emit_report, emit_end;

  // parallel compare, priority encode lowest match
  logic [TABLE_ENTRIES-1:0] match;
  logic          any_hit;
  logic [IW-1:0] first_hit;
  always_comb begin
    any_hit = 1'b0;
    first_hit = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      match[i] = valid_r[i] && key_r[i] == {cur_r.hi, cur_r.lo};
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
      if (match[i]) begin any_hit = 1'b1; first_hit = IW'(i); end
  end

  logic [32:0] pk_sum;
  logic [48:0] by_sum;
  assign pk_sum = {1'b0, txp_r[idx_r]} + {1'b0, rxp_r[idx_r]};
  assign by_sum = {1'b0, txb_r[idx_r]} + {1'b0, rxb_r[idx_r]};

  logic [48:0] add_tx, add_rx;
  assign add_tx = {1'b0, txb_r[hit_idx_r]} + {33'd0, cur_r.size};
  assign add_rx = {1'b0, rxb_r[hit_idx_r]} + {33'd0, cur_r.size};

  // entry idx_r meets both minimums; table holds still during a dump; user must hold minimums still too (unenforced)
  logic qual;
  assign qual = valid_r[idx_r] && pk_sum >= {1'b0, min_packets}
                && by_sum >= {17'd0, min_bytes};

  logic walk_done, table_full;
  assign walk_done = walk_r == CW'(TABLE_ENTRIES);
  assign table_full = used_r >= CW'(TABLE_ENTRIES);

  logic out_free;
  assign out_free = !res_v_r || res_ready;
  assign res_valid = res_v_r;
  assign res = res_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ipfc_pkg::BK_IDLE:
        if (q_valid) begin
          unique case (q_data.cmd)
            ipfc_pkg::CMD_COUNT: st_nxt = ipfc_pkg::BK_SEARCH;
            ipfc_pkg::CMD_DUMP:  st_nxt = ipfc_pkg::BK_DUMP;
            default:             st_nxt = ipfc_pkg::BK_EMIT;
          endcase
        end
      ipfc_pkg::BK_SEARCH: st_nxt = ipfc_pkg::BK_UPDATE;
      ipfc_pkg::BK_UPDATE: st_nxt = ipfc_pkg::BK_EMIT;
      ipfc_pkg::BK_EMIT:   if (out_free) st_nxt = ipfc_pkg::BK_IDLE;
      ipfc_pkg::BK_DUMP:
        if (walk_done) st_nxt = ipfc_pkg::BK_END;
        else st_nxt = ipfc_pkg::BK_DUMP_CHK;
      ipfc_pkg::BK_DUMP_CHK:
        if (!qual || out_free) st_nxt = ipfc_pkg::BK_DUMP;
      ipfc_pkg::BK_END:    if (out_free) st_nxt = ipfc_pkg::BK_IDLE;
      default:             st_nxt = ipfc_pkg::BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop = 1'b0;
    emit_status = 1'b0;
    emit_report = 1'b0;
    emit_end = 1'b0;
    unique case (st_r)
      ipfc_pkg::BK_IDLE:     q_pop = q_valid;
      ipfc_pkg::BK_EMIT:     emit_status = out_free;
      ipfc_pkg::BK_DUMP_CHK: emit_report = qual && out_free;
      ipfc_pkg::BK_END:      emit_end = out_free;
      default: ;
    endcase
  end

  // next result word; only loaded when the output register is free
  always_comb begin
    res_nxt = '0;
    if (emit_report) begin
      res_nxt.kind = ipfc_pkg::KIND_REPORT;
      res_nxt.high_addr = key_r[idx_r][63:32];
      res_nxt.low_addr = key_r[idx_r][31:0];
      res_nxt.tx_byte_count = txb_r[idx_r];
      res_nxt.tx_packet_count = txp_r[idx_r];
      res_nxt.rx_byte_count = rxb_r[idx_r];
      res_nxt.rx_packet_count = rxp_r[idx_r];
    end else if (emit_end) begin
      res_nxt.kind = ipfc_pkg::KIND_END;
      res_nxt.last = 1'b1;
    end else begin
      res_nxt.kind = ipfc_pkg::KIND_STATUS;
      res_nxt.status = stat_r;
      res_nxt.last = 1'b1;
      // ignored packets report a zero pair
      if (cur_r.cmd == ipfc_pkg::CMD_COUNT) begin
        res_nxt.high_addr = cur_r.hi;
        res_nxt.low_addr = cur_r.lo;
      end
    end
  end

  assign res_v_nxt = (emit_status || emit_report || emit_end) || (res_v_r && !res_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ipfc_pkg::BK_IDLE;
      used_r <= '0;
      res_v_r <= 1'b0;
      res_r <= '0;
      walk_r <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) valid_r[i] <= 1'b0;
    end else begin
      st_r <= st_nxt;
      res_v_r <= res_v_nxt;
      if (emit_status || emit_report || emit_end) res_r <= res_nxt;
      unique case (st_r)
        ipfc_pkg::BK_IDLE:
          if (q_valid) begin
            cur_r <= q_data;
            walk_r <= '0;
            stat_r <= ipfc_pkg::ST_IGNORED;
          end
        ipfc_pkg::BK_SEARCH: begin
          hit_r <= any_hit;
          hit_idx_r <= any_hit ? first_hit : used_r[IW-1:0];
        end
        ipfc_pkg::BK_UPDATE: begin
          if (!hit_r && table_full) begin
            stat_r <= ipfc_pkg::ST_DROPPED;
          end else begin
            stat_r <= ipfc_pkg::ST_COUNTED;
            if (!hit_r) begin
              used_r <= used_r + CW'(1);
              valid_r[hit_idx_r] <= 1'b1;
              key_r[hit_idx_r] <= {cur_r.hi, cur_r.lo};
              txb_r[hit_idx_r] <= cur_r.tx ? {32'd0, cur_r.size} : '0;
              rxb_r[hit_idx_r] <= cur_r.tx ? '0 : {32'd0, cur_r.size};
              txp_r[hit_idx_r] <= cur_r.tx ? 32'd1 : 32'd0;
              rxp_r[hit_idx_r] <= cur_r.tx ? 32'd0 : 32'd1;
            end else if (cur_r.tx) begin
              txb_r[hit_idx_r] <= add_tx[48] ? ipfc_pkg::Max48 : add_tx[47:0];
              txp_r[hit_idx_r] <= txp_r[hit_idx_r] + 32'd1;
            end else begin
              rxb_r[hit_idx_r] <= add_rx[48] ? ipfc_pkg::Max48 : add_rx[47:0];
              rxp_r[hit_idx_r] <= rxp_r[hit_idx_r] + 32'd1;
            end
          end
        end
        ipfc_pkg::BK_DUMP:
          if (!walk_done) begin
            idx_r <= walk_r[IW-1:0];
            walk_r <= walk_r + CW'(1);
          end
        ipfc_pkg::BK_END:
          if (out_free) begin
            used_r <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++) valid_r[i] <= 1'b0;
          end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) used_r <= CW'(TABLE_ENTRIES))
    else $error("entry count past table size");
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_v_r && !res_ready) |=> (res_v_r && $stable(res_r)))
    else $error("pending result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ipfc_pkg::BK_END && out_free) |=> used_r == '0)
    else $error("table not cleared after dump");
endmodule

/* design/ip_pair_flow_counter_table_top.sv */
// ip_pair_flow_counter_table_top: top level of the IP pair flow counter table.
// Depends on ipfc_pkg, ipfc_if, ipfc_front, ipfc_back.
`timescale 1ns / 1ps
// Usage:
//  - in channel (valid/ready): one item is a packet observation (operation 0)
//    or a dump request (operation 1). Accepted when valid and ready are high.
//  - out channel (valid/ready): one result per packet (kind 0, status),
//    or for a dump one report per qualifying entry in slot order, then an
//    end marker (kind 2, last 1). The table is cleared after the marker.
//  - cfg port: write enable, index (0 min_packets, 1 min_bytes,
//    2 header_bytes) and 32-bit data; write only while idle.
//  - Front classifies items into a 2-entry queue; back searches the table
//    with a parallel key compare, then updates the counters.
//  - An IPv4 packet holds the back through pop, search, update and emit;
//    a non-IPv4 packet through pop and emit. The back takes no new item
//    before its emit; the front queue accepts items meanwhile until full.
//  - A dump: pop, then a dump and a check state per slot, a last dump
//    state at walk end, then the end marker, each emit waiting on the receiver.
//  - Reset (synchronous, rst_n low) empties the table and the queue and
//    restores header_bytes to 16; no clearing pass is needed.
//  - When the receiver stalls the output register holds its result, the back
//    waits, the queue fills and then in_ch.ready drops.
module ip_pair_flow_counter_table_top #(
  parameter int TABLE_ENTRIES = ipfc_pkg::TableEntriesDefault
) (
  input  logic          clk,
  input  logic          rst_n,
  ipfc_in_if.sink       in_ch,
  ipfc_out_if.source    out_ch,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);
  logic [31:0] min_packets_r, min_bytes_r;
  logic [7:0]  header_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_packets_r <= '0;
      min_bytes_r <= '0;
      header_bytes_r <= 8'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ipfc_pkg::CFG_MIN_PACKETS:  min_packets_r <= cfg_data;
        ipfc_pkg::CFG_MIN_BYTES:    min_bytes_r <= cfg_data;
        ipfc_pkg::CFG_HEADER_BYTES: header_bytes_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic q_valid, q_pop;
  ipfc_pkg::work_t q_data;
  ipfc_pkg::result_t res;

  ipfc_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .operation(in_ch.operation), .eth_type(in_ch.eth_type),
    .source_addr(in_ch.source_addr), .dest_addr(in_ch.dest_addr),
    .frame_length(in_ch.frame_length), .header_bytes(header_bytes_r),
    .q_valid, .q_pop, .q_data
  );

  ipfc_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_data,
    .min_packets(min_packets_r), .min_bytes(min_bytes_r),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res
  );

  assign out_ch.kind = res.kind;
  assign out_ch.status = res.status;
  assign out_ch.high_addr = res.high_addr;
  assign out_ch.low_addr = res.low_addr;
  assign out_ch.tx_byte_count = res.tx_byte_count;
  assign out_ch.tx_packet_count = res.tx_packet_count;
  assign out_ch.rx_byte_count = res.rx_byte_count;
  assign out_ch.rx_packet_count = res.rx_packet_count;
  assign out_ch.last = res.last;
endmodule

/* tb/tb_ip_pair_flow_counter_table_top.sv */
// Testbench for ip_pair_flow_counter_table_top: directed and random packet and
// dump items checked against a scoreboard that models the pair counter table.
// Depends on ipfc_pkg, ipfc_if and the design files.
`timescale 1ns / 1ps
module tb_ip_pair_flow_counter_table_top;
  localparam int Entries = ipfc_pkg::TableEntriesDefault;
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_DUMP = 1'b1;

  // one input item as the sender sees it
  typedef struct {
    logic        operation;
    logic [15:0] eth_type;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [15:0] frame_length;
  } pkt_item_t;

  // Scoreboard: keeps its own copy of the pair table and a queue of
  // expected results; note_item predicts, check_result compares.
  class flow_table_sb;
    logic [31:0] min_packets = 0;
    logic [31:0] min_bytes = 0;
    logic [7:0]  header_bytes = 8'd16;
    bit          slot_valid[Entries];
    logic [63:0] slot_key[Entries];
    logic [47:0] tx_octets[Entries];
    logic [47:0] rx_octets[Entries];
    logic [31:0] tx_pkts[Entries];
    logic [31:0] rx_pkts[Entries];
    int          used = 0;
    ipfc_pkg::result_t expected_results[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          reports_seen = 0;
    int          drops_seen = 0;

    function void clear_pairs();
      foreach (slot_valid[i]) slot_valid[i] = 0;
      used = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == ipfc_pkg::CFG_MIN_PACKETS) min_packets = val;
      else if (idx == ipfc_pkg::CFG_MIN_BYTES) min_bytes = val;
      else if (idx == ipfc_pkg::CFG_HEADER_BYTES) header_bytes = val[7:0];
    endfunction

    function ipfc_pkg::result_t blank(logic [1:0] kind);
      ipfc_pkg::result_t r;
      r = '0;
      r.kind = kind;
      return r;
    endfunction

    function void note_item(pkt_item_t it);
      ipfc_pkg::result_t r;
      logic [32:0] pk_sum;
      logic [48:0] by_sum;
      logic [48:0] add;
      logic [31:0] hi, lo;
      logic [15:0] sz;
      bit tx;
      int slot;
      if (it.operation == OP_DUMP) begin
        for (int i = 0; i < Entries; i++) begin
          if (!slot_valid[i]) continue;
          pk_sum = {1'b0, tx_pkts[i]} + {1'b0, rx_pkts[i]};
          by_sum = {1'b0, tx_octets[i]} + {1'b0, rx_octets[i]};
          if (pk_sum < {1'b0, min_packets}) continue;
          if (by_sum < {17'b0, min_bytes}) continue;
          r = blank(ipfc_pkg::KIND_REPORT);
          r.high_addr = slot_key[i][63:32];
          r.low_addr = slot_key[i][31:0];
          r.tx_byte_count = tx_octets[i];
          r.tx_packet_count = tx_pkts[i];
          r.rx_byte_count = rx_octets[i];
          r.rx_packet_count = rx_pkts[i];
          expected_results.push_back(r);
        end
        r = blank(ipfc_pkg::KIND_END);
        r.last = 1;
        expected_results.push_back(r);
        clear_pairs();
        return;
      end
      r = blank(ipfc_pkg::KIND_STATUS);
      r.last = 1;
      if (it.eth_type != ipfc_pkg::EthIpv4) begin
        r.status = ipfc_pkg::ST_IGNORED;
        expected_results.push_back(r);
        return;
      end
      tx = it.source_addr > it.dest_addr;
      hi = tx ? it.source_addr : it.dest_addr;
      lo = tx ? it.dest_addr : it.source_addr;
      sz = (it.frame_length > {8'd0, header_bytes}) ?
           it.frame_length - {8'd0, header_bytes} : 16'd0;
      r.high_addr = hi;
      r.low_addr = lo;
      slot = -1;
      for (int i = 0; i < Entries; i++)
        if (slot_valid[i] && slot_key[i] == {hi, lo}) begin
          slot = i;
          break;
        end
      if (slot < 0) begin
        if (used >= Entries) begin
          r.status = ipfc_pkg::ST_DROPPED;
          expected_results.push_back(r);
          return;
        end
        slot = used;
        used++;
        slot_valid[slot] = 1;
        slot_key[slot] = {hi, lo};
        tx_octets[slot] = 0;
        rx_octets[slot] = 0;
        tx_pkts[slot] = 0;
        rx_pkts[slot] = 0;
      end
      if (tx) begin
        add = {1'b0, tx_octets[slot]} + {33'd0, sz};
        tx_octets[slot] = add[48] ? ipfc_pkg::Max48 : add[47:0];
        tx_pkts[slot] = tx_pkts[slot] + 32'd1;
      end else begin
        add = {1'b0, rx_octets[slot]} + {33'd0, sz};
        rx_octets[slot] = add[48] ? ipfc_pkg::Max48 : add[47:0];
        rx_pkts[slot] = rx_pkts[slot] + 32'd1;
      end
      r.status = ipfc_pkg::ST_COUNTED;
      expected_results.push_back(r);
    endfunction

    function void check_result(ipfc_pkg::result_t got);
      ipfc_pkg::result_t exp_r;
      results_seen++;
      if (got.kind == ipfc_pkg::KIND_REPORT) reports_seen++;
      if (got.kind == ipfc_pkg::KIND_STATUS && got.status == ipfc_pkg::ST_DROPPED)
        drops_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = expected_results.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_r, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = ipfc_pkg::CFG_MIN_PACKETS;
  logic [31:0] cfg_data = '0;

  ipfc_in_if in_ch();
  ipfc_out_if out_ch();

  flow_table_sb sb = new();

  // idling percentages, changed per phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int dumps_sent = 0;

  always #4 clk = ~clk;

  ip_pair_flow_counter_table_top u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    in_ch.valid = 0;
    in_ch.operation = 0;
    in_ch.eth_type = 0;
    in_ch.source_addr = 0;
    in_ch.dest_addr = 0;
    in_ch.frame_length = 0;
    out_ch.ready = 0;
  end

  // Receiver: ready toggles per stall percentage; results are checked at the
  // edge where valid and ready are both high.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(ipfc_pkg::result_t'{out_ch.kind, out_ch.status,
                        out_ch.high_addr, out_ch.low_addr,
                        out_ch.tx_byte_count, out_ch.tx_packet_count,
                        out_ch.rx_byte_count, out_ch.rx_packet_count, out_ch.last});
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Drive one item, with an optional idle gap first; returns at the accepting
  // edge with valid still high, so the next item can follow without a gap.
  task automatic send_item(pkt_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.operation <= it.operation;
    in_ch.eth_type <= it.eth_type;
    in_ch.source_addr <= it.source_addr;
    in_ch.dest_addr <= it.dest_addr;
    in_ch.frame_length <= it.frame_length;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(it);
    items_sent++;
    if (it.operation == OP_DUMP) dumps_sent++;
  endtask

  task automatic send_pkt(logic [15:0] et, logic [31:0] s, logic [31:0] d,
                          logic [15:0] len);
    send_item('{OP_PACKET, et, s, d, len});
  endtask

  task automatic send_dump();
    pkt_item_t it;
    it = '{OP_DUMP, 16'($urandom), $urandom, $urandom, 16'($urandom)};
    send_item(it);
  endtask

  // Stop sending, wait until all expected results are in, then let the back finish.
  task automatic drain();
    in_ch.valid <= 0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // Random traffic: mostly IPv4 among a small address pool so pairs repeat,
  // with noise ethertypes, wide random addresses and occasional dumps.
  task automatic random_traffic(int count);
    logic [31:0] pool[8];
    logic [31:0] s, d;
    logic [15:0] et;
    foreach (pool[i]) pool[i] = $urandom;
    pool[0] = 32'h0;
    pool[1] = 32'hFFFF_FFFF;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 4) begin
        send_dump();
        continue;
      end
      et = ($urandom_range(9) == 0) ? 16'($urandom) : ipfc_pkg::EthIpv4;
      if ($urandom_range(9) < 2) begin
        s = $urandom;
        d = $urandom;
      end else begin
        s = pool[$urandom_range(7)];
        d = pool[$urandom_range(7)];
      end
      send_pkt(et, s, d, ($urandom_range(9) == 0) ? 16'($urandom) :
               16'($urandom_range(300)));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: non-IPv4, equal addresses, tx/rx orientation, length at and
    // below the header size, extreme lengths and addresses, dump of all.
    send_pkt(16'h86DD, 32'h1, 32'h2, 16'd100);
    send_pkt(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_pkt(16'h0000, 32'h0, 32'h0, 16'h0);
    send_pkt(ipfc_pkg::EthIpv4, 32'h0A00_0001, 32'h0A00_0001, 16'd64);
    send_pkt(ipfc_pkg::EthIpv4, 32'hC0A8_0102, 32'hC0A8_0101, 16'd16);
    send_pkt(ipfc_pkg::EthIpv4, 32'hC0A8_0101, 32'hC0A8_0102, 16'd15);
    send_pkt(ipfc_pkg::EthIpv4, 32'hC0A8_0101, 32'hC0A8_0102, 16'd17);
    send_pkt(ipfc_pkg::EthIpv4, 32'hFFFF_FFFF, 32'h0, 16'hFFFF);
    send_pkt(ipfc_pkg::EthIpv4, 32'h0, 32'hFFFF_FFFF, 16'h0);
    send_pkt(ipfc_pkg::EthIpv4, 32'h5555_AAAA, 32'hAAAA_5555, 16'hAAAA);
    send_pkt(ipfc_pkg::EthIpv4, 32'hAAAA_5555, 32'h5555_AAAA, 16'h5555);
    send_dump();
    // dump of an empty table: only the end marker
    send_dump();
    // fill the table past its size to hit the drop path
    for (int i = 0; i < Entries + 3; i++)
      send_pkt(ipfc_pkg::EthIpv4, 32'h1000_0000 + i, 32'h0100_0000, 16'd80);
    send_pkt(ipfc_pkg::EthIpv4, 32'h1000_0000, 32'h0100_0000, 16'd80);
    send_dump();
    drain();

    // Extreme register settings; minimums at max filter everything.
    write_cfg(ipfc_pkg::CFG_MIN_PACKETS, 32'hFFFF_FFFF);
    write_cfg(ipfc_pkg::CFG_MIN_BYTES, 32'hFFFF_FFFF);
    write_cfg(ipfc_pkg::CFG_HEADER_BYTES, 32'd0);
    random_traffic(40);
    send_dump();
    drain();

    // Mid thresholds, max header; sender stalls.
    write_cfg(ipfc_pkg::CFG_MIN_PACKETS, 32'd2);
    write_cfg(ipfc_pkg::CFG_MIN_BYTES, 32'd50);
    write_cfg(ipfc_pkg::CFG_HEADER_BYTES, 32'd255);
    send_idle_pct = 58;
    random_traffic(100);
    // hold off until every pending result has come
    drain();

    // Receiver stalls, default-like settings.
    write_cfg(ipfc_pkg::CFG_MIN_PACKETS, 32'd0);
    write_cfg(ipfc_pkg::CFG_MIN_BYTES, 32'd0);
    write_cfg(ipfc_pkg::CFG_HEADER_BYTES, 32'd16);
    send_idle_pct = 0;
    recv_stall_pct = 58;
    random_traffic(120);
    send_dump();
    drain();

    // Both idle.
    write_cfg(ipfc_pkg::CFG_MIN_PACKETS, 32'd1);
    write_cfg(ipfc_pkg::CFG_HEADER_BYTES, 32'd40);
    send_idle_pct = 20;
    recv_stall_pct = 20;
    random_traffic(120);
    send_dump();
    drain();

    $display("covered %0d items (%0d dumps), %0d results, %0d entry reports, %0d drops",
             items_sent, dumps_sent, sb.results_seen, sb.reports_seen, sb.drops_seen);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // timeout guard
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

/* ip_pair_flow_counter_table_top.f */
design/ipfc_pkg.sv
design/ipfc_if.sv
design/ipfc_front.sv
design/ipfc_back.sv
design/ip_pair_flow_counter_table_top.sv
tb/tb_ip_pair_flow_counter_table_top.sv
